>>> sv/frwd_pkg.sv
// Package for the frame rotation block: field widths, fixed-point constants,
// request and result types, pipeline latencies and the Q1.16 product helper.
// No dependencies.
package frwd_pkg;

  localparam int AngleBits = 16;
  localparam int AngW      = 16;
  localparam int VecBits   = 32;

  localparam int NumTerms = 5;
  localparam int CellLat  = 3;
  localparam int TrigLat  = 5 + NumTerms * CellLat;
  localparam int MatLat   = 4;
  localparam int PipeLat  = TrigLat + MatLat;

  localparam logic [30:0] Q30One    = 31'h4000_0000;
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;

  localparam logic [1:0] OpPlain = 2'd0;
  localparam logic [1:0] OpIncl  = 2'd1;
  localparam logic [1:0] OpPeri  = 2'd2;

  typedef logic signed [17:0]        trig_val_t;
  typedef logic signed [VecBits-1:0] vec_t;

  typedef struct packed {
    trig_val_t s;
    trig_val_t c;
  } trig_t;

  typedef struct packed {
    logic [AngW-1:0] from_incl;
    logic [AngW-1:0] from_peri;
    logic [AngW-1:0] to_incl;
    logic [AngW-1:0] to_peri;
    vec_t            vec_x;
    vec_t            vec_y;
    vec_t            vec_z;
    logic [1:0]      op;
    logic            wrt_source;
  } req_t;

  typedef struct packed {
    vec_t out_x;
    vec_t out_y;
    vec_t out_z;
    logic saturated;
  } res_t;

  function automatic int term_div(int idx);
    int d;
    d = 6;
    unique case (idx)
      0:       d = 110;
      1:       d = 72;
      2:       d = 42;
      3:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  function automatic trig_val_t mul16(trig_val_t a, trig_val_t b);
    logic signed [35:0] p;
    p = 36'(a) * 36'(b) + 36'sd32768;
    return p[33:16];
  endfunction

endpackage

>>> sv/frwd_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on frwd_pkg for the payload types.
interface frwd_req_if;
  logic              valid;
  logic              ready;
  frwd_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface frwd_res_if;
  logic              valid;
  logic              ready;
  frwd_pkg::res_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/frwd_dly.sv
// Enabled shift line of N stages, W bits wide, cleared by reset.
// No dependencies.
module frwd_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign d_o = pipe_q[N-1];

endmodule

>>> sv/frwd_cell.sv
// One Horner step of the sine series: a' = 2^30 - floor(floor(t2*a/2^30)/K).
// Three stages: product, reciprocal quotient estimate, correction. Uses frwd_pkg.
module frwd_cell #(
  parameter int K = 6
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] t_i,
  input  logic [31:0] t2_i,
  input  logic [30:0] a_i,
  output logic [30:0] t_o,
  output logic [31:0] t2_o,
  output logic [30:0] a_o
);

  localparam logic [32:0] Recip = 33'((64'd1 << 35) / K);

  logic [31:0] y_q, y2_q;
  logic [30:0] ta_q, tb_q, tc_q;
  logic [31:0] t2a_q, t2b_q, t2c_q;
  logic [29:0] q0_q;
  logic [30:0] a_q;

  logic [62:0] ya;
  logic [64:0] qm;
  logic [36:0] qk, r;
  logic [29:0] q;

  always_comb begin
    ya = 63'(t2_i) * 63'(a_i);
    qm = 65'(y_q) * 65'(Recip);
    qk = 37'(q0_q) * 37'(K);
    r  = 37'(y2_q) - qk;
    q  = (r >= 37'(K)) ? q0_q + 30'd1 : q0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q   <= ya[61:30];
      ta_q  <= t_i;
      t2a_q <= t2_i;
      q0_q  <= qm[64:35];
      y2_q  <= y_q;
      tb_q  <= ta_q;
      t2b_q <= t2a_q;
      a_q   <= frwd_pkg::Q30One - {1'b0, q};
      tc_q  <= tb_q;
      t2c_q <= t2b_q;
    end
  end

  assign t_o  = tc_q;
  assign t2_o = t2c_q;
  assign a_o  = a_q;

endmodule

>>> sv/frwd_trig.sv
// Pipelined sine and cosine of a 32-bit phase, Q1.16 results.
// Two rows of frwd_cell (sine and cosine of the quadrant fraction); uses frwd_pkg, frwd_dly.
module frwd_trig (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [31:0]     phase_i,
  output frwd_pkg::trig_t trig_o
);

  localparam int NT = frwd_pkg::NumTerms;

  logic [30:0] x_q   [2];
  logic [30:0] t1_q  [2];
  logic [30:0] t_q   [2];
  logic [31:0] t2_q  [2];
  logic [16:0] q16_q [2];
  logic [1:0]  quad;
  frwd_pkg::trig_t trig_q;

  logic [30:0] ct_w  [2][NT+1];
  logic [31:0] ct2_w [2][NT+1];
  logic [30:0] ca_w  [2][NT+1];

  frwd_dly #(.W(2), .N(frwd_pkg::TrigLat - 1)) u_quad (
    .clk_i, .rst_ni, .en_i, .d_i(phase_i[31:30]), .d_o(quad)
  );

  for (genvar ch = 0; ch < 2; ch++) begin : g_row
    logic [61:0] pt, ptt, pr;
    logic [31:0] rc, rr;

    always_comb begin
      pt  = 62'(x_q[ch]) * 62'(frwd_pkg::HalfPiQ30);
      ptt = 62'(t1_q[ch]) * 62'(t1_q[ch]);
      pr  = 62'(ct_w[ch][NT]) * 62'(ca_w[ch][NT]);
      rc  = (pr[61:30] > 32'(frwd_pkg::Q30One)) ? 32'(frwd_pkg::Q30One) : pr[61:30];
      rr  = rc + 32'd8192;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t1_q[ch]  <= pt[60:30];
        t_q[ch]   <= t1_q[ch];
        t2_q[ch]  <= ptt[61:30];
        q16_q[ch] <= rr[30:14];
      end
    end

    assign ct_w[ch][0]  = t_q[ch];
    assign ct2_w[ch][0] = t2_q[ch];
    assign ca_w[ch][0]  = frwd_pkg::Q30One;

    for (genvar i = 0; i < NT; i++) begin : g_cell
      frwd_cell #(.K(frwd_pkg::term_div(i))) u_cell (
        .clk_i,
        .en_i,
        .t_i (ct_w[ch][i]),
        .t2_i(ct2_w[ch][i]),
        .a_i (ca_w[ch][i]),
        .t_o (ct_w[ch][i+1]),
        .t2_o(ct2_w[ch][i+1]),
        .a_o (ca_w[ch][i+1])
      );
    end
  end

  frwd_pkg::trig_val_t su, cu;
  frwd_pkg::trig_t     trig_d;

  always_comb begin
    su = frwd_pkg::trig_val_t'({1'b0, q16_q[0]});
    cu = frwd_pkg::trig_val_t'({1'b0, q16_q[1]});
    unique case (quad)
      2'd0: begin trig_d.s = su;  trig_d.c = cu;  end
      2'd1: begin trig_d.s = cu;  trig_d.c = -su; end
      2'd2: begin trig_d.s = -su; trig_d.c = -cu; end
      default: begin trig_d.s = -cu; trig_d.c = su; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= {1'b0, phase_i[29:0]};
      x_q[1] <= frwd_pkg::Q30One - {1'b0, phase_i[29:0]};
      trig_q <= trig_d;
    end
  end

  assign trig_o = trig_q;

endmodule

>>> sv/frwd_mat.sv
// Matrix build, matrix-vector product and saturation, four stages.
// Uses frwd_pkg.
module frwd_mat (
  input  logic            clk_i,
  input  logic            en_i,
  input  frwd_pkg::trig_t tf_i,
  input  frwd_pkg::trig_t tt_i,
  input  frwd_pkg::trig_t td_i,
  input  frwd_pkg::vec_t  vx_i,
  input  frwd_pkg::vec_t  vy_i,
  input  frwd_pkg::vec_t  vz_i,
  input  logic [1:0]      op_i,
  input  logic            wrt_i,
  output frwd_pkg::res_t  res_o
);

  localparam int VB = frwd_pkg::VecBits;

  frwd_pkg::trig_val_t sd, cd, ss, cc, sc, cs;
  frwd_pkg::trig_val_t ss_q, cc_q, sc_q, cs_q, cd_q, m01_q, m10_q, m12_q, m21_q;
  frwd_pkg::vec_t      v1_q [3];
  frwd_pkg::vec_t      v2_q [3];
  logic signed [18:0]  e_q  [3][3];
  logic signed [34:0]  p_q  [3][3];
  frwd_pkg::res_t      res_q;

  always_comb begin
    sd = td_i.s;
    cd = td_i.c;
    if (op_i == frwd_pkg::OpPeri) begin
      if (wrt_i) begin
        cd = td_i.s;
        sd = -td_i.c;
      end else begin
        cd = -td_i.s;
        sd = td_i.c;
      end
    end
    if (op_i == frwd_pkg::OpIncl && wrt_i) begin
      ss = frwd_pkg::mul16(tt_i.s, tf_i.c);
      cc = -frwd_pkg::mul16(tt_i.c, tf_i.s);
      sc = -frwd_pkg::mul16(tt_i.s, tf_i.s);
      cs = frwd_pkg::mul16(tt_i.c, tf_i.c);
    end else if (op_i == frwd_pkg::OpIncl) begin
      ss = frwd_pkg::mul16(tt_i.c, tf_i.s);
      cc = -frwd_pkg::mul16(tt_i.s, tf_i.c);
      sc = frwd_pkg::mul16(tt_i.c, tf_i.c);
      cs = -frwd_pkg::mul16(tt_i.s, tf_i.s);
    end else begin
      ss = frwd_pkg::mul16(tt_i.s, tf_i.s);
      cc = frwd_pkg::mul16(tt_i.c, tf_i.c);
      sc = frwd_pkg::mul16(tt_i.s, tf_i.c);
      cs = frwd_pkg::mul16(tt_i.c, tf_i.s);
    end
  end

  logic signed [50:0] pr  [3][3];
  logic signed [36:0] acc [3];
  logic               clip [3];
  frwd_pkg::vec_t     sat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pr[r][c] = 51'(e_q[r][c]) * 51'(v2_q[c]) + 51'sd32768;
      end
      acc[r] = 37'(p_q[r][0]) + 37'(p_q[r][1]) + 37'(p_q[r][2]);
      if (acc[r] > 37'sd2147483647) begin
        sat[r]  = {1'b0, {(VB-1){1'b1}}};
        clip[r] = 1'b1;
      end else if (acc[r] < -37'sd2147483648) begin
        sat[r]  = {1'b1, {(VB-1){1'b0}}};
        clip[r] = 1'b1;
      end else begin
        sat[r]  = acc[r][VB-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ss_q  <= ss;
      cc_q  <= cc;
      sc_q  <= sc;
      cs_q  <= cs;
      cd_q  <= cd;
      m01_q <= -frwd_pkg::mul16(tt_i.c, sd);
      m10_q <= frwd_pkg::mul16(tf_i.c, sd);
      m12_q <= -frwd_pkg::mul16(tf_i.s, sd);
      m21_q <= frwd_pkg::mul16(tt_i.s, sd);
      v1_q[0] <= vx_i;
      v1_q[1] <= vy_i;
      v1_q[2] <= vz_i;

      e_q[0][0] <= 19'(ss_q) + 19'(frwd_pkg::mul16(cc_q, cd_q));
      e_q[0][1] <= 19'(m01_q);
      e_q[0][2] <= 19'(sc_q) - 19'(frwd_pkg::mul16(cs_q, cd_q));
      e_q[1][0] <= 19'(m10_q);
      e_q[1][1] <= 19'(cd_q);
      e_q[1][2] <= 19'(m12_q);
      e_q[2][0] <= 19'(cs_q) - 19'(frwd_pkg::mul16(sc_q, cd_q));
      e_q[2][1] <= 19'(m21_q);
      e_q[2][2] <= 19'(cc_q) + 19'(frwd_pkg::mul16(ss_q, cd_q));
      v2_q <= v1_q;

      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) p_q[r][c] <= pr[r][c][50:16];
      end

      res_q.out_x     <= sat[0];
      res_q.out_y     <= sat[1];
      res_q.out_z     <= sat[2];
      res_q.saturated <= clip[0] | clip[1] | clip[2];
    end
  end

  assign res_o = res_q;

endmodule

>>> sv/frame_rotation_with_derivative.sv
// Top level: frame rotation with optional inclination/periapsis derivative.
// Uses frwd_pkg, frwd_if, frwd_dly, frwd_trig, frwd_mat.
//
//   channel  direction  handshake      payload
//   req_i    in         valid/ready    frwd_pkg::req_t
//   res_o    out        valid/ready    frwd_pkg::res_t
//
// One request per cycle while the pipeline is not held; each result passes
// through the trig rows of cells and then the matrix stages.
// The whole pipeline advances together; it holds only while res_o has a
// result that is not taken, and req_i.ready drops in exactly those cycles.
// Reset clears the valid line and the delay lines; the arithmetic registers
// carry no reset.
module frame_rotation_with_derivative (
  input  logic       clk_i,
  input  logic       rst_ni,
  frwd_req_if.sink   req_i,
  frwd_res_if.source res_o
);

  localparam int Sh = 32 - frwd_pkg::AngleBits;
  localparam int SideW = 3 * frwd_pkg::VecBits + 3;

  logic        en;
  logic [31:0] ph_f, ph_t, ph_d, diff;
  frwd_pkg::trig_t tf, tt, td;
  logic [SideW-1:0] side_in, side_out;
  frwd_pkg::vec_t   vx, vy, vz;
  logic [1:0]       op_d;
  logic             wrt_d;

  assign en          = !res_o.valid || res_o.ready;
  assign req_i.ready = en;

  assign diff = {16'b0, req_i.payload.to_peri} - {16'b0, req_i.payload.from_peri};
  assign ph_f = {16'b0, req_i.payload.from_incl} << Sh;
  assign ph_t = {16'b0, req_i.payload.to_incl} << Sh;
  assign ph_d = diff << Sh;

  frwd_trig u_trig_f (.clk_i, .rst_ni, .en_i(en), .phase_i(ph_f), .trig_o(tf));
  frwd_trig u_trig_t (.clk_i, .rst_ni, .en_i(en), .phase_i(ph_t), .trig_o(tt));
  frwd_trig u_trig_d (.clk_i, .rst_ni, .en_i(en), .phase_i(ph_d), .trig_o(td));

  assign side_in = {req_i.payload.vec_x, req_i.payload.vec_y, req_i.payload.vec_z,
                    req_i.payload.op, req_i.payload.wrt_source};

  frwd_dly #(.W(SideW), .N(frwd_pkg::TrigLat)) u_side (
    .clk_i, .rst_ni, .en_i(en), .d_i(side_in), .d_o(side_out)
  );

  assign {vx, vy, vz, op_d, wrt_d} = side_out;

  frwd_mat u_mat (
    .clk_i,
    .en_i (en),
    .tf_i (tf),
    .tt_i (tt),
    .td_i (td),
    .vx_i (vx),
    .vy_i (vy),
    .vz_i (vz),
    .op_i (op_d),
    .wrt_i(wrt_d),
    .res_o(res_o.payload)
  );

  frwd_dly #(.W(1), .N(frwd_pkg::PipeLat)) u_valid (
    .clk_i, .rst_ni, .en_i(en), .d_i(req_i.valid), .d_o(res_o.valid)
  );

endmodule

>>> sv/frwd_chk.sv
// Port-level checks for the frame rotation block, bound to the top level.
// Uses frwd_pkg.
module frwd_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input frwd_pkg::res_t out_data_i
);

  localparam frwd_pkg::vec_t VMax = {1'b0, {(frwd_pkg::VecBits-1){1'b1}}};
  localparam frwd_pkg::vec_t VMin = {1'b1, {(frwd_pkg::VecBits-1){1'b0}}};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("request ready does not follow result stall");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.saturated |->
      out_data_i.out_x == VMax || out_data_i.out_x == VMin ||
      out_data_i.out_y == VMax || out_data_i.out_y == VMin ||
      out_data_i.out_z == VMax || out_data_i.out_z == VMin)
    else $error("saturated flag without a clipped component");

  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid out of reset");

endmodule

bind frame_rotation_with_derivative frwd_chk u_frwd_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (req_i.ready),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_data_i (res_o.payload)
);

>>> dv/frwd_rotation_checker.sv
// Checker for the frame rotation block: watches the request and result
// channels, predicts each rotated vector and compares it field by field.
// Depends on frwd_pkg and the channel interfaces in frwd_if.
module frwd_rotation_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  frwd_req_if   req_i,
  frwd_res_if   res_i,
  output int    fail_count_o,
  output int    pending_o
);

  frwd_pkg::res_t pending_rotations[$];

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned t, t2, a, r;
    int unsigned divs[5];
    divs = '{110, 72, 42, 20, 6};
    if (x > 64'd1073741824) x = 64'd1073741824;
    t  = (x * 64'd1686629713) >> 30;
    t2 = (t * t) >> 30;
    a  = 64'd1073741824;
    for (int i = 0; i < 5; i++) a = 64'd1073741824 - (((t2 * a) >> 30) / divs[i]);
    r = (t * a) >> 30;
    if (r > 64'd1073741824) r = 64'd1073741824;
    return r;
  endfunction

  function automatic longint q16_of(longint unsigned v);
    return longint'((v + 64'd8192) >> 14);
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint s, output longint c);
    logic [31:0]     phase;
    longint unsigned frac;
    longint          su, cu;
    phase = {ang, 16'h0};
    frac  = longint'(phase[29:0]);
    su    = q16_of(sine_q30(frac));
    cu    = q16_of(sine_q30(64'd1073741824 - frac));
    case (phase[31:30])
      2'd0: begin s = su;  c = cu;  end
      2'd1: begin s = cu;  c = -su; end
      2'd2: begin s = -su; c = -cu; end
      default: begin s = -cu; c = su; end
    endcase
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic frwd_pkg::res_t rotate_vector(frwd_pkg::req_t r);
    longint sf, cf, st, ct, sd, cd, ss, cc, sc, cs, tmp, acc;
    longint m[3][3];
    longint v[3];
    logic   sat;
    logic [15:0] dw;
    frwd_pkg::vec_t outs[3];
    frwd_pkg::res_t res;
    dw = r.to_peri - r.from_peri;
    sin_cos(r.from_incl, sf, cf);
    sin_cos(r.to_incl, st, ct);
    sin_cos(dw, sd, cd);
    v[0] = longint'(r.vec_x);
    v[1] = longint'(r.vec_y);
    v[2] = longint'(r.vec_z);
    if (r.op == frwd_pkg::OpPeri) begin
      tmp = cd;
      if (r.wrt_source) begin
        cd = sd;
        sd = -tmp;
      end else begin
        cd = -sd;
        sd = tmp;
      end
    end
    if (r.op == frwd_pkg::OpIncl && r.wrt_source) begin
      ss = qmul(st, cf);
      cc = -qmul(ct, sf);
      sc = -qmul(st, sf);
      cs = qmul(ct, cf);
    end else if (r.op == frwd_pkg::OpIncl) begin
      ss = qmul(ct, sf);
      cc = -qmul(st, cf);
      sc = qmul(ct, cf);
      cs = -qmul(st, sf);
    end else begin
      ss = qmul(st, sf);
      cc = qmul(ct, cf);
      sc = qmul(st, cf);
      cs = qmul(ct, sf);
    end
    m[0][0] = ss + qmul(cc, cd);
    m[0][1] = -qmul(ct, sd);
    m[0][2] = sc - qmul(cs, cd);
    m[1][0] = qmul(cf, sd);
    m[1][1] = cd;
    m[1][2] = -qmul(sf, sd);
    m[2][0] = cs - qmul(sc, cd);
    m[2][1] = qmul(st, sd);
    m[2][2] = cc + qmul(ss, cd);
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += (m[i][j] * v[j] + 64'sd32768) >>> 16;
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
        sat = 1'b1;
      end
      if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
        sat = 1'b1;
      end
      outs[i] = acc[31:0];
    end
    res.out_x     = outs[0];
    res.out_y     = outs[1];
    res.out_z     = outs[2];
    res.saturated = sat;
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = pending_rotations.size();

  always @(posedge clk_i) begin
    frwd_pkg::res_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) pending_rotations.push_back(rotate_vector(req_i.payload));
      if (res_i.valid && res_i.ready) begin
        if (pending_rotations.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pending_rotations.pop_front();
          if (res_i.payload.out_x !== want.out_x)
            report("out_x", res_i.payload.out_x, want.out_x);
          if (res_i.payload.out_y !== want.out_y)
            report("out_y", res_i.payload.out_y, want.out_y);
          if (res_i.payload.out_z !== want.out_z)
            report("out_z", res_i.payload.out_z, want.out_z);
          if (res_i.payload.saturated !== want.saturated)
            report("saturated", res_i.payload.saturated, want.saturated);
        end
      end
    end
  end
endmodule

>>> dv/frame_rotation_with_derivative_tb.sv
// Testbench top for the frame rotation block: drives directed and random
// requests in bursts, stalls the result side, and reports the verdict.
// Depends on frwd_pkg, frwd_if, the block and frwd_rotation_checker.
module frame_rotation_with_derivative_tb;

  localparam int NumRandom  = 1550;
  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   sent;
  int   cycles;

  frwd_req_if req_if ();
  frwd_res_if res_if ();

  frame_rotation_with_derivative dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  frwd_rotation_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic frwd_pkg::vec_t rand_vec();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0: return frwd_pkg::vec_t'(raw);
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return frwd_pkg::vec_t'($signed(raw) >>> $urandom_range(4, 20));
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] quarter;
    quarter = {2'($urandom_range(0, 3)), 14'h0};
    case ($urandom_range(0, 7))
      0: return quarter;
      1: return quarter + 16'($urandom_range(0, 3)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frwd_pkg::req_t rand_request();
    frwd_pkg::req_t r;
    r.from_incl  = rand_angle();
    r.from_peri  = rand_angle();
    r.to_incl    = rand_angle();
    r.to_peri    = rand_angle();
    r.vec_x      = rand_vec();
    r.vec_y      = rand_vec();
    r.vec_z      = rand_vec();
    r.op         = 2'($urandom_range(0, 3));
    r.wrt_source = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send(frwd_pkg::req_t r);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_directed();
    frwd_pkg::req_t r;
    logic [15:0] angles[6];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000};
    for (int op = 0; op < 4; op++) begin
      for (int w = 0; w < 2; w++) begin
        r.from_incl  = angles[(op + w) % 6];
        r.from_peri  = angles[(op * 2 + w) % 6];
        r.to_incl    = angles[(op + 3 * w + 1) % 6];
        r.to_peri    = angles[(op + 5) % 6];
        r.vec_x      = 32'sh0000_8000;
        r.vec_y      = -32'sh0001_0000;
        r.vec_z      = 32'sh0000_4000;
        r.op         = 2'(op);
        r.wrt_source = 1'(w);
        send(r);
      end
    end
    for (int i = 0; i < 6; i++) begin
      r.from_incl  = angles[i];
      r.from_peri  = 16'hffff;
      r.to_incl    = angles[5 - i];
      r.to_peri    = 16'h0000;
      r.vec_x      = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
      r.vec_y      = (i % 3) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      r.vec_z      = (i < 3) ? 32'sh7fff_ffff : 32'sh0000_0000;
      r.op         = (i < 2) ? frwd_pkg::OpPlain :
                     ((i < 4) ? frwd_pkg::OpIncl : frwd_pkg::OpPeri);
      r.wrt_source = 1'(i % 2);
      send(r);
    end
  endtask

  initial begin
    int burst;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    sent           = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    burst = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (burst == 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst = $urandom_range(1, 40);
      end
      send(rand_request());
      burst--;
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int mode;
    int span;
    logic held;
    res_if.ready = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(posedge clk_i);
        if (!held && sent >= 300) begin
          held = 1'b1;
          res_if.ready <= 1'b0;
          repeat (150) @(posedge clk_i);
        end
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= ((c % 7) < 4);
        endcase
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end
endmodule
